/* hdl/pfhm_pkg.sv */
`timescale 1ns / 1ps
// Package for the polarity flip Hadamard mixer: sample and word types, widths,
// the 1/sqrt(n) scale table and the butterfly function. Depends on nothing.

package pfhm_pkg;

  localparam int unsigned MAXCH        = 8;
  localparam int unsigned SAMPLE_W     = 24;
  localparam int unsigned SUM_W        = SAMPLE_W + 4;
  localparam int unsigned SCALE_W      = 32;
  localparam int unsigned PROD_W       = SUM_W + SCALE_W;
  localparam int unsigned SCALE_SHIFT  = 30;
  localparam int unsigned RND_W        = PROD_W - SCALE_SHIFT;
  localparam int unsigned CHANNELS_DEF = 8;
  localparam int unsigned MASK_W       = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [SCALE_W-1:0]  scale_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [RND_W-1:0]    rnd_t;
  typedef sum_t    [MAXCH-1:0]        lane_arr_t;
  typedef prod_t   [MAXCH-1:0]        prod_arr_t;
  typedef sample_t [MAXCH-1:0]        sample_arr_t;

  typedef struct packed {
    sample_t ch0_in;
    sample_t ch1_in;
    sample_t ch2_in;
    sample_t ch3_in;
    sample_t ch4_in;
    sample_t ch5_in;
    sample_t ch6_in;
    sample_t ch7_in;
  } in_word_t;

  typedef struct packed {
    sample_t ch0_out;
    sample_t ch1_out;
    sample_t ch2_out;
    sample_t ch3_out;
    sample_t ch4_out;
    sample_t ch5_out;
    sample_t ch6_out;
    sample_t ch7_out;
  } out_word_t;

  // 1/sqrt(n) in Q2.30, rounded to nearest.
  function automatic scale_t inv_sqrt_q30(input int unsigned n);
    scale_t k;
    unique case (n)
      1:       k = scale_t'(1073741824);
      2:       k = scale_t'(759250125);
      3:       k = scale_t'(619925131);
      4:       k = scale_t'(536870912);
      5:       k = scale_t'(480191942);
      6:       k = scale_t'(438353264);
      7:       k = scale_t'(405836263);
      default: k = scale_t'(379625062);
    endcase
    return k;
  endfunction

  // One transform stage of span h over n active lanes; a lane whose partner
  // lies beyond the active lanes passes through unchanged.
  function automatic lane_arr_t butterfly(input lane_arr_t v, input int unsigned h,
                                          input int unsigned n);
    lane_arr_t r;
    r = v;
    for (int unsigned j = 0; j < MAXCH; j++) begin
      if (((j & h) == 0) && (j + h < n) && (j + h < MAXCH)) begin
        r[j]     = v[j] + v[j + h];
        r[j + h] = v[j] - v[j + h];
      end
    end
    return r;
  endfunction

endpackage

/* hdl/polarity_flip_hadamard_mixer.sv */
`timescale 1ns / 1ps
// Top level of the polarity flip Hadamard mixer: polarity flip, three butterfly
// stages, scaling multiply, rounding and saturation. Depends on pfhm_pkg.

// While out_stall is low, the mixer takes one frame of up to eight Q1.23 samples
// per cycle and returns one mixed frame per cycle. Each word passes through the
// stages in order: polarity flip with the first butterfly, the second and third
// butterflies, the 1/sqrt(CHANNELS) multiply, then rounding and saturation into
// the output register. Each stage holds its own valid bit, so empty stages close
// up under a stall and the input is only stalled once every stage holds a word.
// Lanes at or above CHANNELS read as zero. The polarity mask should be written
// only while the pipeline is empty.
module polarity_flip_hadamard_mixer #(
  parameter int unsigned CHANNELS = pfhm_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pfhm_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pfhm_pkg::out_word_t            out_data,
  input  logic                           cfg_wr_en,
  input  logic [pfhm_pkg::MASK_W-1:0]    cfg_wr_data
);

  localparam int unsigned NSTG = 5;
  localparam int unsigned NCH  = (CHANNELS > pfhm_pkg::MAXCH) ? pfhm_pkg::MAXCH :
                                 (CHANNELS < 1) ? 1 : CHANNELS;
  localparam pfhm_pkg::scale_t SCALE = pfhm_pkg::inv_sqrt_q30(NCH);
  localparam pfhm_pkg::prod_t  ROUND = pfhm_pkg::prod_t'(1) <<
                                       (pfhm_pkg::SCALE_SHIFT - 1);
  localparam pfhm_pkg::rnd_t   SAT_HI = pfhm_pkg::rnd_t'(8388607);
  localparam pfhm_pkg::rnd_t   SAT_LO = -pfhm_pkg::rnd_t'(8388608);

  logic [pfhm_pkg::MASK_W-1:0] polarity_mask;
  logic [NSTG-1:0]             vld;
  logic [NSTG-1:0]             en;

  pfhm_pkg::sample_arr_t in_lane;
  pfhm_pkg::lane_arr_t   flip;
  pfhm_pkg::lane_arr_t   s1;
  pfhm_pkg::lane_arr_t   s2;
  pfhm_pkg::lane_arr_t   s3;
  pfhm_pkg::prod_arr_t   prod;
  pfhm_pkg::sample_arr_t sat_next;
  pfhm_pkg::sample_arr_t out_lane;

  always_ff @(posedge clk) begin
    if (rst) begin
      polarity_mask <= '0;
    end else if (cfg_wr_en) begin
      polarity_mask <= cfg_wr_data;
    end
  end

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k + 1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k - 1];
        end
      end
    end
  end

  assign in_lane[0] = in_data.ch0_in;
  assign in_lane[1] = in_data.ch1_in;
  assign in_lane[2] = in_data.ch2_in;
  assign in_lane[3] = in_data.ch3_in;
  assign in_lane[4] = in_data.ch4_in;
  assign in_lane[5] = in_data.ch5_in;
  assign in_lane[6] = in_data.ch6_in;
  assign in_lane[7] = in_data.ch7_in;

  always_comb begin
    for (int unsigned i = 0; i < pfhm_pkg::MAXCH; i++) begin
      if (i >= NCH) begin
        flip[i] = '0;
      end else if (polarity_mask[i]) begin
        flip[i] = -pfhm_pkg::sum_t'(in_lane[i]);
      end else begin
        flip[i] = pfhm_pkg::sum_t'(in_lane[i]);
      end
    end
  end

  always_comb begin
    pfhm_pkg::rnd_t rnd_val;
    for (int unsigned i = 0; i < pfhm_pkg::MAXCH; i++) begin
      rnd_val = pfhm_pkg::rnd_t'((prod[i] + ROUND) >>> pfhm_pkg::SCALE_SHIFT);
      priority if (rnd_val > SAT_HI) begin
        sat_next[i] = pfhm_pkg::sample_t'(SAT_HI);
      end else if (rnd_val < SAT_LO) begin
        sat_next[i] = pfhm_pkg::sample_t'(SAT_LO);
      end else begin
        sat_next[i] = pfhm_pkg::sample_t'(rnd_val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1 <= pfhm_pkg::butterfly(flip, 1, NCH);
    end
    if (en[1]) begin
      s2 <= pfhm_pkg::butterfly(s1, 2, NCH);
    end
    if (en[2]) begin
      s3 <= pfhm_pkg::butterfly(s2, 4, NCH);
    end
    if (en[3]) begin
      for (int unsigned i = 0; i < pfhm_pkg::MAXCH; i++) begin
        prod[i] <= s3[i] * SCALE;
      end
    end
    if (en[4]) begin
      out_lane <= sat_next;
    end
  end

  assign out_data.ch0_out = out_lane[0];
  assign out_data.ch1_out = out_lane[1];
  assign out_data.ch2_out = out_lane[2];
  assign out_data.ch3_out = out_lane[3];
  assign out_data.ch4_out = out_lane[4];
  assign out_data.ch5_out = out_lane[5];
  assign out_data.ch6_out = out_lane[6];
  assign out_data.ch7_out = out_lane[7];

  // The input is only held off when the first stage holds a word.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> vld[0])
    else $error("input stalled with an empty first stage");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !vld[NSTG-2] |=> !out_valid)
    else $error("result repeated after it was taken");

  // A stalled stage keeps its word until the next stage frees.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-2] && !en[NSTG-1] |=> vld[NSTG-2] && vld[NSTG-1])
    else $error("word lost behind a stalled output");

  // The mask clears at reset.
  a_mask_rst: assert property (@(posedge clk)
    $past(rst) && !$past(cfg_wr_en) |-> polarity_mask == '0)
    else $error("polarity mask not cleared by reset");

  // Lanes four to seven give zero where they lie at or above the channel count.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((NCH > 7) || out_lane[7] == '0) && ((NCH > 6) || out_lane[6] == '0)
                  && ((NCH > 5) || out_lane[5] == '0) && ((NCH > 4) || out_lane[4] == '0))
    else $error("unused lane carries a non-zero sample");

endmodule

/* tb/sv/mix_frame_checker.sv */
`timescale 1ns / 1ps
// Checker for the polarity flip Hadamard mixer: watches the input and output,
// predicts each mixed frame and compares it field by field. Depends on pfhm_pkg.

module mix_frame_checker #(
  parameter int unsigned CHANNELS = pfhm_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  pfhm_pkg::in_word_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  pfhm_pkg::out_word_t         out_data,
  input  logic                        cfg_wr_en,
  input  logic [pfhm_pkg::MASK_W-1:0] cfg_wr_data,
  output int                          mismatches,
  output int                          frames_pending
);

  import pfhm_pkg::*;

  localparam longint SCALE_Q30 =
    (CHANNELS <= 1) ? 64'sd1073741824 :
    (CHANNELS == 2) ? 64'sd759250125  :
    (CHANNELS == 3) ? 64'sd619925131  :
    (CHANNELS == 4) ? 64'sd536870912  :
    (CHANNELS == 5) ? 64'sd480191942  :
    (CHANNELS == 6) ? 64'sd438353264  :
    (CHANNELS == 7) ? 64'sd405836263  : 64'sd379625062;
  localparam longint ROUND_HALF = 64'sd536870912;
  localparam longint OUT_MAX    = 64'sd8388607;
  localparam longint OUT_MIN    = -64'sd8388608;

  out_word_t        expected_frames[$];
  logic [MASK_W-1:0] polarity;
  int               fail_count = 0;
  int               waiting = 0;
  int               words_seen = 0;

  assign mismatches     = fail_count;
  assign frames_pending = waiting;

  function automatic out_word_t mix_frame(input in_word_t w, input logic [MASK_W-1:0] mask);
    sample_arr_t src;
    sample_arr_t res;
    longint      lane[MAXCH];
    longint      a;
    longint      b;
    longint      prod;
    longint      rnd;
    int          n;
    n = (CHANNELS > MAXCH) ? MAXCH : ((CHANNELS < 1) ? 1 : CHANNELS);
    src = sample_arr_t'(w);
    for (int i = 0; i < MAXCH; i++) begin
      lane[i] = 0;
      if (i < n) begin
        lane[i] = longint'(src[MAXCH-1-i]);
        if (mask[i]) begin
          lane[i] = -lane[i];
        end
      end
    end
    for (int h = 1; h < n; h = h * 2) begin
      for (int i = 0; i < n; i = i + 2 * h) begin
        for (int j = i; j < i + h && j < n; j++) begin
          if (j + h < n) begin
            a = lane[j];
            b = lane[j + h];
            lane[j]     = a + b;
            lane[j + h] = a - b;
          end
        end
      end
    end
    res = '0;
    for (int i = 0; i < n; i++) begin
      prod = lane[i] * SCALE_Q30;
      rnd = (prod + ROUND_HALF) >>> 30;
      if (rnd > OUT_MAX) begin
        rnd = OUT_MAX;
      end
      if (rnd < OUT_MIN) begin
        rnd = OUT_MIN;
      end
      res[MAXCH-1-i] = sample_t'(rnd);
    end
    return out_word_t'(res);
  endfunction

  always @(posedge clk) begin
    out_word_t   want;
    sample_arr_t want_a;
    sample_arr_t got_a;
    if (rst) begin
      expected_frames.delete();
      polarity = '0;
      waiting = 0;
    end else begin
      if (cfg_wr_en) begin
        polarity = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        expected_frames.push_back(mix_frame(in_data, polarity));
      end
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("word %0d arrived with nothing expected: %h", words_seen, out_data);
          end
        end else begin
          want = expected_frames.pop_front();
          want_a = sample_arr_t'(want);
          got_a = sample_arr_t'(out_data);
          for (int i = 0; i < MAXCH; i++) begin
            if (got_a[MAXCH-1-i] !== want_a[MAXCH-1-i]) begin
              fail_count++;
              if (fail_count <= 10) begin
                $display("word %0d ch%0d_out: expected %0d, got %0d", words_seen, i,
                         want_a[MAXCH-1-i], got_a[MAXCH-1-i]);
              end
            end
          end
        end
        words_seen++;
      end
      waiting = expected_frames.size();
    end
  end

endmodule

/* tb/sv/polarity_flip_hadamard_mixer_test.sv */
`timescale 1ns / 1ps
// Top of the mixer testbench: clock, reset, directed and random frames, polarity mask
// changes and receiver stalls. Depends on pfhm_pkg, the mixer and mix_frame_checker.

module polarity_flip_hadamard_mixer_test;

  import pfhm_pkg::*;

  localparam int unsigned MIX_CHANNELS = CHANNELS_DEF;
  localparam sample_t     SAMPLE_MAX   = 24'sh7FFFFF;
  localparam sample_t     SAMPLE_MIN   = 24'sh800000;
  localparam int          PHASES       = 8;
  localparam int          PHASE_WORDS  = 118;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_data;
  logic              cfg_wr_en;
  logic [MASK_W-1:0] cfg_wr_data;
  int                mismatches;
  int                frames_pending;

  int in_idle_pct  = 16;
  int out_idle_pct = 16;
  int rx_holdoff_cycles = 0;

  polarity_flip_hadamard_mixer #(
    .CHANNELS(MIX_CHANNELS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  mix_frame_checker #(
    .CHANNELS(MIX_CHANNELS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatches    (mismatches),
    .frames_pending(frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_holdoff_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (rx_holdoff_cycles) @(posedge clk);
        rx_holdoff_cycles = 0;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  task automatic send_frame(input in_word_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_mask(input logic [MASK_W-1:0] m);
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return '1;
      4, 5:    return sample_t'(int'($urandom_range(512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic in_word_t pick_frame();
    sample_arr_t a;
    sample_t     v;
    if ($urandom_range(7) == 0) begin
      v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      for (int i = 0; i < MAXCH; i++) begin
        a[i] = v;
      end
    end else begin
      for (int i = 0; i < MAXCH; i++) begin
        a[i] = pick_sample();
      end
    end
    return in_word_t'(a);
  endfunction

  initial begin
    sample_arr_t       a;
    logic [MASK_W-1:0] phase_mask[PHASES];
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst         <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Extremes, alternating signs and one impulse per channel with no flips.
    load_mask(8'h00);
    send_frame('0);
    send_frame(in_word_t'({MAXCH{SAMPLE_MAX}}));
    send_frame(in_word_t'({MAXCH{SAMPLE_MIN}}));
    send_frame(in_word_t'({(MAXCH/2){SAMPLE_MAX, SAMPLE_MIN}}));
    send_frame(in_word_t'({MAXCH{24'hFFFFFF}}));
    for (int i = 0; i < MAXCH; i++) begin
      a = '0;
      a[MAXCH-1-i] = SAMPLE_MAX;
      send_frame(in_word_t'(a));
    end

    // Every channel flipped, so full scale negative becomes positive full scale.
    load_mask(8'hFF);
    send_frame(in_word_t'({MAXCH{SAMPLE_MIN}}));
    send_frame(in_word_t'({MAXCH{SAMPLE_MAX}}));
    a = '0;
    a[MAXCH-1] = SAMPLE_MIN;
    send_frame(in_word_t'(a));

    load_mask(8'hA5);
    send_frame(in_word_t'({(MAXCH/2){SAMPLE_MIN, SAMPLE_MAX}}));
    send_frame(pick_frame());
    send_frame(pick_frame());

    phase_mask[0] = 8'h5A;
    phase_mask[1] = 8'h80;
    phase_mask[2] = 8'h01;
    phase_mask[3] = 8'hFF;
    phase_mask[4] = MASK_W'($urandom);
    phase_mask[5] = MASK_W'($urandom);
    phase_mask[6] = 8'h00;
    phase_mask[7] = MASK_W'($urandom);

    for (int p = 0; p < PHASES; p++) begin
      load_mask(phase_mask[p]);
      in_idle_pct  = (p == 3) ? 0 : 16;
      out_idle_pct = (p == 3) ? 0 : 16;
      if (p == 2) begin
        in_idle_pct = 0;
        rx_holdoff_cycles = 80;
      end
      for (int k = 0; k < PHASE_WORDS; k++) begin
        send_frame(pick_frame());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && frames_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* polarity_flip_hadamard_mixer.f */
hdl/pfhm_pkg.sv
hdl/polarity_flip_hadamard_mixer.sv
tb/sv/mix_frame_checker.sv
tb/sv/polarity_flip_hadamard_mixer_test.sv
